>>> sv/ccl_pkg.sv
package ccl_pkg;

	// sample and detector widths
	localparam int SAMPLE_BITS     = 16;
	localparam int ERR_W           = SAMPLE_BITS + 1;
	localparam int IN_TDATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8;

	// loop arithmetic widths
	localparam int PHASE_FRAC_BITS = 28;
	localparam int GAIN_FRAC_BITS  = 16;
	localparam int GAIN_W          = 17;
	localparam int PHASE_W         = 32;
	localparam int FREQ_W          = 31;
	localparam int FSAT_W          = 32;
	localparam int OUT_W           = ERR_W + PHASE_W + FREQ_W;
	localparam int OUT_TDATA_W     = ((OUT_W + 7) / 8) * 8;

	// gain product scaling, arithmetic shift right (or left when negative)
	localparam int PROD_SHIFT = GAIN_FRAC_BITS + SAMPLE_BITS - 1 - PHASE_FRAC_BITS;
	localparam int SHR        = (PROD_SHIFT > 0) ? PROD_SHIFT : 0;
	localparam int SHL        = (PROD_SHIFT < 0) ? -PROD_SHIFT : 0;
	localparam int PROD_W     = GAIN_W + 1 + ERR_W;
	localparam int WIDE_W     = PROD_W + SHL;
	localparam int TERM_W     = PROD_W + SHL - SHR;

	// frequency sum before saturation, phase sum before wrap
	localparam int FSUM_W = ((TERM_W > FREQ_W) ? TERM_W : FREQ_W) + 1;
	localparam int PSUM_W = FSAT_W + 3;

	// two pi in phase units, rounded to nearest from the 2^32 scale
	localparam longint TAU_Q32   = 64'sd26986075409;
	localparam int     TAU_SHIFT = 32 - PHASE_FRAC_BITS;
	localparam longint TAU       = (TAU_Q32 + (64'sd1 <<< (TAU_SHIFT - 1))) >>> TAU_SHIFT;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN   = 2'd3;

	// error queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [GAIN_W-1:0]        prop_gain;
		logic [GAIN_W-1:0]        integ_gain;
		logic signed [FREQ_W-1:0] freq_max;
		logic signed [FREQ_W-1:0] freq_min;
	} cfg_regs_t;

	typedef struct packed {
		logic                    valid;
		logic signed [ERR_W-1:0] err;
	} q_head_t;

	// gain times error, scaled to phase units with floor rounding
	function automatic logic signed [TERM_W-1:0] scale_prod(input logic signed [PROD_W-1:0] p);
		logic signed [WIDE_W-1:0] w;
		w = WIDE_W'(p) <<< SHL;
		return TERM_W'(w >>> SHR);
	endfunction

endpackage

>>> sv/ccl_front.sv
module ccl_front
	import ccl_pkg::*;
(
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // sample_i, sample_q
	input  logic                    q_full,
	output logic                    push,
	output logic signed [ERR_W-1:0] push_err
);

	logic signed [SAMPLE_BITS-1:0] si;
	logic signed [SAMPLE_BITS-1:0] sq;
	logic signed [ERR_W-1:0]       si_x;
	logic signed [ERR_W-1:0]       sq_x;
	logic signed [ERR_W-1:0]       term_q;
	logic signed [ERR_W-1:0]       term_i;

	assign si = s_axis_tdata[SAMPLE_BITS-1:0];
	assign sq = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

	// accept whenever the queue has room
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	// limiter detector: sign(i)*q - sign(q)*i, zero if either part is zero
	always_comb begin
		si_x   = ERR_W'(si);
		sq_x   = ERR_W'(sq);
		term_q = (si > 0) ? sq_x : -sq_x;
		term_i = (sq > 0) ? si_x : -si_x;
		if (si == '0 || sq == '0) begin
			push_err = '0;
		end else begin
			push_err = term_q - term_i;
		end
	end

endmodule

>>> sv/ccl_queue.sv
module ccl_queue
	import ccl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic signed [ERR_W-1:0] push_err,
	input  logic                    pop,
	output logic                    full,
	output q_head_t                 head
);

	logic signed [ERR_W-1:0] mem_q [QDEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.err   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_err;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/ccl_back.sv
module ccl_back
	import ccl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_regs_t              cfg,
	input  q_head_t                head,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata  // phase_error, loop_phase, loop_freq
);

	localparam logic signed [FSUM_W-1:0] FSAT_HI = FSUM_W'((64'sd1 <<< (FSAT_W - 1)) - 1);
	localparam logic signed [FSUM_W-1:0] FSAT_LO = FSUM_W'(-(64'sd1 <<< (FSAT_W - 1)));
	localparam logic signed [PSUM_W-1:0] TAU1    = PSUM_W'(TAU);
	localparam logic signed [PSUM_W-1:0] TAU2    = PSUM_W'(2 * TAU);

	logic en;

	// stage 1: gain products
	logic                     vld_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [TERM_W-1:0] ti_s1;
	logic signed [TERM_W-1:0] tp_s1;
	logic signed [PROD_W-1:0] prod_i;
	logic signed [PROD_W-1:0] prod_p;

	// stage 2: frequency loop
	logic                     vld_s2;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [TERM_W-1:0] tp_s2;
	logic signed [FSAT_W-1:0] fsat_s2;
	logic signed [FREQ_W-1:0] fclamp_s2;
	logic signed [FREQ_W-1:0] freq_q;
	logic signed [FSUM_W-1:0] fsum;
	logic signed [FSAT_W-1:0] fsat;
	logic signed [FREQ_W-1:0] fclamp;

	// output stage: phase loop
	logic                      out_vld_q;
	logic signed [ERR_W-1:0]   out_err_q;
	logic signed [PHASE_W-1:0] out_phase_q;
	logic signed [FREQ_W-1:0]  out_freq_q;
	logic signed [PHASE_W-1:0] phase_q;
	logic signed [PSUM_W-1:0]  psum;
	logic signed [PSUM_W-1:0]  pwrap;

	// back pipeline moves unless the output holds an untaken item
	assign en  = !out_vld_q || m_axis_tready;
	assign pop = en && head.valid;

	assign prod_i = PROD_W'($signed({1'b0, cfg.integ_gain})) * PROD_W'(head.err);
	assign prod_p = PROD_W'($signed({1'b0, cfg.prop_gain})) * PROD_W'(head.err);

	// frequency update, saturation to 32 bits, then clamp
	always_comb begin
		fsum = FSUM_W'(freq_q) + FSUM_W'(ti_s1);
		if (fsum > FSAT_HI) begin
			fsat = FSAT_W'(FSAT_HI);
		end else if (fsum < FSAT_LO) begin
			fsat = FSAT_W'(FSAT_LO);
		end else begin
			fsat = FSAT_W'(fsum);
		end
		if (fsat > FSAT_W'(cfg.freq_max)) begin
			fclamp = cfg.freq_max;
		end else if (fsat < FSAT_W'(cfg.freq_min)) begin
			fclamp = cfg.freq_min;
		end else begin
			fclamp = FREQ_W'(fsat);
		end
	end

	// phase update and wrap by at most two turns either way
	always_comb begin
		psum = PSUM_W'(phase_q) + PSUM_W'(fsat_s2) + PSUM_W'(tp_s2);
		if (psum > TAU2) begin
			pwrap = psum - TAU2;
		end else if (psum > TAU1) begin
			pwrap = psum - TAU1;
		end else if (psum < -TAU2) begin
			pwrap = psum + TAU2;
		end else if (psum < -TAU1) begin
			pwrap = psum + TAU1;
		end else begin
			pwrap = psum;
		end
	end

	// valid flags and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			freq_q    <= '0;
			phase_q   <= '0;
		end else if (en) begin
			vld_s1    <= head.valid;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
			if (vld_s1) begin
				freq_q <= fclamp;
			end
			if (vld_s2) begin
				phase_q <= PHASE_W'(pwrap);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			err_s1      <= head.err;
			ti_s1       <= scale_prod(prod_i);
			tp_s1       <= scale_prod(prod_p);
			err_s2      <= err_s1;
			tp_s2       <= tp_s1;
			fsat_s2     <= fsat;
			fclamp_s2   <= fclamp;
			out_err_q   <= err_s2;
			out_phase_q <= PHASE_W'(pwrap);
			out_freq_q  <= fclamp_s2;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_freq_q, out_phase_q, out_err_q});

endmodule

>>> sv/qpsk_costas_carrier_loop.sv
// QPSK Costas carrier loop, second order, one derotated sample per item.
// Input stream s_axis: tdata holds sample_i (bits 15:0) and sample_q (31:16).
// Output stream m_axis: tdata holds phase_error (16:0), loop_phase (48:17)
// and loop_freq (79:49); one result item per input item, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index selecting prop_gain (0),
// integ_gain (1), freq_max (2) or freq_min (3), value in cfg_data; cfg_ready
// is always high. Write registers only while no items are in flight.
// Throughput: one item per cycle while m_axis is not stalled. The frequency
// accumulator closes its loop in the stage 2 registers (add, saturate,
// clamp) and the phase accumulator in the output stage (three-input add
// and wrap), so neither recurrence limits the rate. A taken input is
// written into the queue, then passes through stage 1, stage 2 and the output stage.
// A four-entry error queue sits between the detector front and the loop
// back; when m_axis_tready is low with a result waiting, the back pipeline
// holds, the queue fills, and s_axis_tready drops only once the queue is full.
// Reset (arst_n low) clears the gains, clamps, phase and frequency to zero
// and empties the queue and pipeline; no clearing pass follows.
module qpsk_costas_carrier_loop
	import ccl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample_i, sample_q
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // phase_error, loop_phase, loop_freq
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_regs_t               cfg_q;
	logic                    q_full;
	logic                    push;
	logic signed [ERR_W-1:0] push_err;
	logic                    pop;
	q_head_t                 head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_data[GAIN_W-1:0];
				REG_FREQ_MAX:   cfg_q.freq_max   <= cfg_data[FREQ_W-1:0];
				REG_FREQ_MIN:   cfg_q.freq_min   <= cfg_data[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	ccl_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.push          (push),
		.push_err      (push_err)
	);

	ccl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_err (push_err),
		.pop      (pop),
		.full     (q_full),
		.head     (head)
	);

	ccl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> sv/ccl_checker.sv
module ccl_checker
	import ccl_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam logic signed [PHASE_W-1:0] TAU_PH = PHASE_W'(TAU);

	logic signed [PHASE_W-1:0] out_phase;
	logic signed [ERR_W-1:0]   out_err;

	assign out_phase = m_axis_tdata[ERR_W+PHASE_W-1:ERR_W];
	assign out_err   = m_axis_tdata[ERR_W-1:0];

	// a stalled result keeps its valid
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its data
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// the wrapped phase stays within one turn either way
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_phase <= TAU_PH) && (out_phase >= -TAU_PH))
		else $error("loop phase outside the wrap range");

	// the detector never reaches the most negative code
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_err != {1'b1, {(ERR_W-1){1'b0}}})
		else $error("phase error outside the detector range");

endmodule

bind qpsk_costas_carrier_loop ccl_checker u_ccl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
